// ----- rtl/core/mwo_pkg.sv -----
`timescale 1ns / 1ps

package mwo_pkg;

  localparam int SAMPLE_W = 16;
  localparam int AMP_W    = 15;
  localparam int PERIOD_W = 16;
  localparam int PHASE_W  = 32;
  localparam int STEP_W   = 15;
  localparam int LEVEL_W  = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // sine table entries; a power of two, indexed by the top phase bits
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 17'sd32767;

  localparam logic [63:0] FULL_SCALE  = 64'd32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_SAW    = 2'd1,
    SHAPE_SQUARE = 2'd2,
    SHAPE_TRI    = 2'd3
  } shape_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_SHAPE = 3'd0,
    REG_AMPLITUDE  = 3'd1,
    REG_PERIOD     = 3'd2,
    REG_PHASE_STEP = 3'd3,
    REG_SAW_STEP   = 3'd4,
    REG_TRI_STEP   = 3'd5
  } cfg_reg_t;

  // Clamp a stepped level to +-32767.
  function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [LEVEL_W:0] v);
    logic signed [LEVEL_W:0] hi;
    logic signed [LEVEL_W:0] lo;
    hi = 18'sd32767;
    lo = -18'sd32767;
    if (v > hi) begin
      return LEVEL_MAX;
    end else if (v < lo) begin
      return -LEVEL_MAX;
    end
    return v[LEVEL_W-1:0];
  endfunction

  // One sine table entry, round(32767*sin(2*pi*idx/2**abits)), by a Q30
  // Taylor series (odd terms to x**17). Evaluated at elaboration only.
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned idx,
                                                            input int unsigned abits);
    logic [63:0]               turn;
    logic [63:0]               r;
    logic [63:0]               x;
    logic [63:0]               x2;
    logic [63:0]               term;
    logic [63:0]               mag;
    logic signed [63:0]        sum;
    logic [1:0]                quad;
    logic signed [SAMPLE_W-1:0] m16;
    turn = 64'(idx) << (32 - abits);
    quad = turn[31:30];
    r    = {34'd0, turn[29:0]};
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    mag = (($unsigned(sum) * FULL_SCALE) + (64'd1 << 29)) >> 30;
    if (mag > FULL_SCALE) begin
      mag = FULL_SCALE;
    end
    m16 = mag[SAMPLE_W-1:0];
    return quad[1] ? -m16 : m16;
  endfunction

endpackage

// ----- rtl/core/mwo_in_if.sv -----
`timescale 1ns / 1ps

interface mwo_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

// ----- rtl/core/mwo_out_if.sv -----
`timescale 1ns / 1ps

interface mwo_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mwo_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/mwo_cfg_if.sv -----
`timescale 1ns / 1ps

interface mwo_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mwo_pkg::CFG_IDX_W-1:0]      index;
  logic [mwo_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/multi_waveform_oscillator_unit.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Payload               Transfer
// in_chan  in   advance (1b)          valid & ready; advance=0 is taken and dropped
// out_chan out  sample (16b, Q1.15)   valid & ready; one sample per advance=1
// cfg_chan in   index (3b), data (32b) valid & ready; ready is always high
//
// One item per cycle sustained while out_chan is ready. The middle stage
// registers the sine ROM read; the result register, the amplitude multiply.
// rst_n is synchronous, active low; it restores the register defaults and
// clears phase, level and tick counter. A stalled out_chan holds the result
// register; one more tick is still taken into the middle stage.

module multi_waveform_oscillator_unit (
  input  logic      clk,
  input  logic      rst_n,
  mwo_in_if.sink    in_chan,
  mwo_out_if.source out_chan,
  mwo_cfg_if.sink   cfg_chan
);

  localparam int ABITS = $clog2(mwo_pkg::SINE_TABLE_DEPTH);
  localparam int SW    = mwo_pkg::SAMPLE_W;
  localparam int LW    = mwo_pkg::LEVEL_W;
  localparam int PW    = mwo_pkg::PERIOD_W;

  // Configuration registers
  mwo_pkg::shape_t                 wave_shape_r;
  logic [mwo_pkg::AMP_W-1:0]       amplitude_r;
  logic [PW-1:0]                   period_r;
  logic [mwo_pkg::PHASE_W-1:0]     phase_step_r;
  logic [mwo_pkg::STEP_W-1:0]      saw_step_r;
  logic [mwo_pkg::STEP_W-1:0]      tri_step_r;

  // Oscillator state
  logic [mwo_pkg::PHASE_W-1:0]     phase_accum_r, phase_accum_nxt;
  logic signed [LW-1:0]            ramp_level_r, ramp_level_nxt;
  logic [PW-1:0]                   tick_count_r, tick_count_nxt;

  // Stage 1: ROM word / direct sample
  logic                            s1_valid_r;
  logic                            s1_sine_r;
  logic signed [SW-1:0]            s1_direct_r, s1_direct_nxt;
  logic signed [SW-1:0]            s1_rom_r;

  // Stage 2: result register
  logic                            out_valid_r;
  logic signed [SW-1:0]            out_sample_r, out_sample_nxt;

  logic in_xfer, tick_go, s1_ready, s2_ready;

  //--------------------------------------------------------------------------
  // Sine table: constant contents built at elaboration, registered read
  //--------------------------------------------------------------------------
  logic signed [SW-1:0] sine_rom [mwo_pkg::SINE_TABLE_DEPTH];

  for (genvar g = 0; g < mwo_pkg::SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic signed [SW-1:0] ENTRY = mwo_pkg::sine_entry(g, ABITS);
    assign sine_rom[g] = ENTRY;
  end

  //--------------------------------------------------------------------------
  // Handshake
  //--------------------------------------------------------------------------
  assign s2_ready       = !out_valid_r || out_chan.ready;
  assign s1_ready       = !s1_valid_r || s2_ready;
  assign in_chan.ready  = s1_ready;
  assign in_xfer        = in_chan.valid && s1_ready;
  assign tick_go        = in_xfer && in_chan.advance;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.sample = out_sample_r;

  //--------------------------------------------------------------------------
  // Stage 0: state update for the accepted tick
  //--------------------------------------------------------------------------
  logic signed [LW-1:0]  amp_s;
  logic signed [LW-1:0]  saw_base;
  logic signed [LW:0]    saw_sum, tri_sum;
  logic [PW:0]           tick_inc;
  logic [PW-1:0]         tick_wrap;
  logic [PW+1:0]         period_x3;
  logic [PW-1:0]         q1, q3;
  logic                  tri_rise;
  logic [ABITS-1:0]      rom_idx;

  always_comb begin
    amp_s     = LW'(amplitude_r);
    // saw restarts at -amplitude once it reaches the peak
    saw_base  = (ramp_level_r >= amp_s) ? -amp_s : ramp_level_r;
    saw_sum   = (LW+1)'(saw_base) + (LW+1)'(saw_step_r);
    tick_inc  = (PW+1)'(tick_count_r) + (PW+1)'(1);
    tick_wrap = (tick_inc >= (PW+1)'(period_r)) ? '0 : tick_inc[PW-1:0];
    period_x3 = (PW+2)'(period_r) + {1'b0, period_r, 1'b0};
    q1        = period_r >> 2;
    q3        = period_x3[PW+1:2];
    // rising in the first and last quarters
    tri_rise  = (tick_count_r < q1) || (tick_count_r >= q3);
    tri_sum   = tri_rise ? (LW+1)'(ramp_level_r) + (LW+1)'(tri_step_r)
                         : (LW+1)'(ramp_level_r) - (LW+1)'(tri_step_r);

    phase_accum_nxt = phase_accum_r;
    ramp_level_nxt  = ramp_level_r;
    tick_count_nxt  = tick_count_r;
    s1_direct_nxt   = '0;

    case (wave_shape_r)
      mwo_pkg::SHAPE_SINE: begin
        phase_accum_nxt = phase_accum_r + phase_step_r;
      end
      mwo_pkg::SHAPE_SAW: begin
        ramp_level_nxt = mwo_pkg::sat_level(saw_sum);
        s1_direct_nxt  = SW'(ramp_level_nxt);
      end
      mwo_pkg::SHAPE_SQUARE: begin
        s1_direct_nxt  = (tick_count_r < (period_r >> 1)) ? SW'(amp_s) : SW'(-amp_s);
        tick_count_nxt = tick_wrap;
      end
      mwo_pkg::SHAPE_TRI: begin
        ramp_level_nxt = mwo_pkg::sat_level(tri_sum);
        s1_direct_nxt  = SW'(ramp_level_nxt);
        tick_count_nxt = tick_wrap;
      end
      default: begin
        s1_direct_nxt = '0;
      end
    endcase

    // table index is the top bits of the advanced phase
    rom_idx = phase_accum_nxt[mwo_pkg::PHASE_W-1 -: ABITS];
  end

  //--------------------------------------------------------------------------
  // Stage 2 datapath: scale the ROM magnitude by the amplitude, round half up
  //--------------------------------------------------------------------------
  logic                  rom_neg;
  logic [SW-1:0]         rom_abs;
  logic [2*mwo_pkg::AMP_W:0] scaled;
  logic signed [SW-1:0]  sine_mag;

  always_comb begin
    rom_neg  = s1_rom_r[SW-1];
    rom_abs  = rom_neg ? SW'(-s1_rom_r) : SW'(s1_rom_r);
    scaled   = (2*mwo_pkg::AMP_W+1)'(rom_abs[mwo_pkg::AMP_W-1:0])
             * (2*mwo_pkg::AMP_W+1)'(amplitude_r)
             + (2*mwo_pkg::AMP_W+1)'(16384);
    sine_mag = SW'(scaled[2*mwo_pkg::AMP_W:mwo_pkg::AMP_W]);
    if (s1_sine_r) begin
      out_sample_nxt = rom_neg ? -sine_mag : sine_mag;
    end else begin
      out_sample_nxt = s1_direct_r;
    end
  end

  //--------------------------------------------------------------------------
  // Registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_shape_r  <= mwo_pkg::SHAPE_SINE;
      amplitude_r   <= 15'd32767;
      period_r      <= 16'd100;
      phase_step_r  <= 32'd42949673;
      saw_step_r    <= 15'd655;
      tri_step_r    <= 15'd1310;
    end else if (cfg_chan.valid) begin
      case (mwo_pkg::cfg_reg_t'(cfg_chan.index))
        mwo_pkg::REG_WAVE_SHAPE: wave_shape_r <= mwo_pkg::shape_t'(cfg_chan.data[1:0]);
        mwo_pkg::REG_AMPLITUDE:  amplitude_r  <= cfg_chan.data[mwo_pkg::AMP_W-1:0];
        mwo_pkg::REG_PERIOD:     period_r     <= cfg_chan.data[PW-1:0];
        mwo_pkg::REG_PHASE_STEP: phase_step_r <= cfg_chan.data[mwo_pkg::PHASE_W-1:0];
        mwo_pkg::REG_SAW_STEP:   saw_step_r   <= cfg_chan.data[mwo_pkg::STEP_W-1:0];
        mwo_pkg::REG_TRI_STEP:   tri_step_r   <= cfg_chan.data[mwo_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_accum_r <= '0;
      ramp_level_r  <= '0;
      tick_count_r  <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (tick_go) begin
        phase_accum_r <= phase_accum_nxt;
        ramp_level_r  <= ramp_level_nxt;
        tick_count_r  <= tick_count_nxt;
      end
      if (s1_ready) begin
        s1_valid_r <= tick_go;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_sine_r   <= (wave_shape_r == mwo_pkg::SHAPE_SINE);
      s1_direct_r <= s1_direct_nxt;
      s1_rom_r    <= sine_rom[rom_idx];
    end
    if (s2_ready && s1_valid_r) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  //--------------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------------
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ramp_level_r <= mwo_pkg::LEVEL_MAX) && (ramp_level_r >= -mwo_pkg::LEVEL_MAX))
    else $error("ramp level outside +-32767");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sample_r != -16'sd32768))
    else $error("sample reached -32768");

  a_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(tick_go && ((wave_shape_r == mwo_pkg::SHAPE_SQUARE) ||
                  (wave_shape_r == mwo_pkg::SHAPE_TRI))) |=> $stable(tick_count_r))
    else $error("tick counter moved without a square/triangle tick");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> s1_valid_r)
    else $error("middle stage lost an item under stall");

endmodule

// ----- test/mwo_sample_checker.sv -----
`timescale 1ns / 1ps

module mwo_sample_checker
  import mwo_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_advance,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_sample,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         samples_due,
  output int                         fail_count
);

  localparam int          ROM_DEPTH   = SINE_TABLE_DEPTH;
  localparam int          ROM_ABITS   = $clog2(ROM_DEPTH);
  localparam int          LEVEL_LIM   = 32767;
  localparam logic [63:0] QUARTER_Q30 = 64'd1686629713;

  int sine_tab [ROM_DEPTH];

  // Register copies
  shape_t              shape_sel;
  logic [AMP_W-1:0]    amp_reg;
  logic [PERIOD_W-1:0] period_reg;
  logic [PHASE_W-1:0]  phase_inc;
  logic [STEP_W-1:0]   saw_inc;
  logic [STEP_W-1:0]   tri_inc;

  // Oscillator state, shared between shapes
  logic [PHASE_W-1:0]  phase_acc;
  int                  level;
  int                  tick;

  logic signed [SAMPLE_W-1:0] expected_q [$];
  int                         errs = 0;

  // Sine table: Q30 Taylor series over one quadrant, folded by quadrant.
  initial begin
    logic [63:0]        turn;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      turn = 64'(i) << (32 - ROM_ABITS);
      r    = {34'd0, turn[29:0]};
      if (turn[30]) begin
        r = (64'd1 << 30) - r;
      end
      x    = (r * QUARTER_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      mag = (($unsigned(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      sine_tab[i] = turn[31] ? -int'(mag) : int'(mag);
    end
  end

  function automatic int clamp_level(input int v);
    if (v > LEVEL_LIM) begin
      return LEVEL_LIM;
    end
    if (v < -LEVEL_LIM) begin
      return -LEVEL_LIM;
    end
    return v;
  endfunction

  function automatic void step_tick();
    if (tick + 1 >= int'(period_reg)) begin
      tick = 0;
    end else begin
      tick = tick + 1;
    end
  endfunction

  // Moves the oscillator on by one tick and returns the sample it yields.
  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    int amp;
    int period;
    int word;
    int mag;
    int s;
    amp    = int'(amp_reg);
    period = int'(period_reg);
    case (shape_sel)
      SHAPE_SINE: begin
        phase_acc = phase_acc + phase_inc;
        word      = sine_tab[phase_acc[PHASE_W-1 -: ROM_ABITS]];
        mag       = (word < 0) ? -word : word;
        mag       = (mag * amp + 16384) >>> 15;
        s         = (word < 0) ? -mag : mag;
      end
      SHAPE_SAW: begin
        if (level >= amp) begin
          level = -amp;
        end
        level = clamp_level(level + int'(saw_inc));
        s     = level;
      end
      SHAPE_SQUARE: begin
        s = (tick < period / 2) ? amp : -amp;
        step_tick();
      end
      default: begin
        if (tick < period / 4 || tick >= (3 * period) / 4) begin
          level = clamp_level(level + int'(tri_inc));
        end else begin
          level = clamp_level(level - int'(tri_inc));
        end
        s = level;
        step_tick();
      end
    endcase
    return SAMPLE_W'(s);
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      shape_sel  = SHAPE_SINE;
      amp_reg    = 15'd32767;
      period_reg = 16'd100;
      phase_inc  = 32'd42949673;
      saw_inc    = 15'd655;
      tri_inc    = 15'd1310;
      phase_acc  = '0;
      level      = 0;
      tick       = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WAVE_SHAPE: shape_sel  = shape_t'(cfg_data[1:0]);
          REG_AMPLITUDE:  amp_reg    = cfg_data[AMP_W-1:0];
          REG_PERIOD:     period_reg = cfg_data[PERIOD_W-1:0];
          REG_PHASE_STEP: phase_inc  = cfg_data[PHASE_W-1:0];
          REG_SAW_STEP:   saw_inc    = cfg_data[STEP_W-1:0];
          REG_TRI_STEP:   tri_inc    = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errs++;
          $display("%0t: expected no sample, got %0d", $time, out_sample);
        end else begin
          want = expected_q.pop_front();
          if (out_sample !== want) begin
            errs++;
            $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, out_sample);
          end
        end
      end
      if (in_valid && in_ready && in_advance) begin
        expected_q.push_back(next_sample());
      end
    end
    samples_due <= expected_q.size();
    fail_count  <= errs;
  end

endmodule

// ----- test/tb_multi_waveform_oscillator_unit.sv -----
`timescale 1ns / 1ps

module tb_multi_waveform_oscillator_unit;
  import mwo_pkg::*;

  localparam int PIPE_LAT     = 2;       // tick transfer to sample: middle stage, then result register
  localparam int RANDOM_TICKS = 570;     // advance=1 transfers in the random part
  localparam int HOLD_CYCLES  = 60;      // long receiver hold-off
  localparam int CYCLE_LIMIT  = 200000;  // hard stop for a hung run

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  int src_idle_pct  = 25;  // chance in 100 that the sender idles before a transfer
  int sink_idle_pct = 45;  // chance in 100 that the receiver drops ready in a cycle
  int hold_left     = 0;   // cycles of forced receiver hold-off still to run
  int cycle_cnt     = 0;
  int samples_due;
  int fail_count;

  mwo_in_if  in_chan ();
  mwo_out_if out_chan ();
  mwo_cfg_if cfg_chan ();

  multi_waveform_oscillator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predicts every sample and compares it as it leaves the block.
  mwo_sample_checker sample_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_advance  (in_chan.advance),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_sample  (out_chan.sample),
    .cfg_valid   (cfg_chan.valid),
    .cfg_ready   (cfg_chan.ready),
    .cfg_index   (cfg_chan.index),
    .cfg_data    (cfg_chan.data),
    .samples_due (samples_due),
    .fail_count  (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a sample.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_multi_waveform_oscillator_unit: done, errors");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a solid hold-off when one is requested.
  // The hold-off is counted here so the sender keeps offering ticks meanwhile.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // One tick transfer. valid stays high on return so back-to-back ticks never
  // drop it; it only goes low ahead of an idle gap or in quiesce().
  task automatic send_tick(input logic adv);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_chan.valid   <= 1'b0;
      in_chan.advance <= 1'($urandom_range(1));  // junk while idle
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.advance <= adv;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Stop offering ticks, wait for every predicted sample, then give the
  // pipeline time to drop any advance=0 transfer still inside.
  task automatic quiesce();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (samples_due != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Register write; bits above the field width carry junk the block must drop.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    logic [31:0] keep;
    case (idx)
      REG_WAVE_SHAPE:                           keep = 32'h0000_0003;
      REG_AMPLITUDE, REG_SAW_STEP, REG_TRI_STEP: keep = 32'h0000_7FFF;
      REG_PERIOD:                               keep = 32'h0000_FFFF;
      default:                                  keep = 32'hFFFF_FFFF;
    endcase
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= (val & keep) | ($urandom & ~keep);
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int          ticks_sent;
    int          burst;
    int          seg;
    logic [31:0] v;

    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.advance = 1'b0;
    cfg_chan.valid  = 1'b0;
    cfg_chan.index  = '0;
    cfg_chan.data   = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed part ----
    // Reset defaults: sine at the default step; a dropped advance=0 in between.
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    // Quarter-turn steps move a quarter of the table each tick, one per quadrant.
    quiesce();
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    repeat (4) send_tick(1'b1);

    // Sine scaled to nothing, then full scale with the largest step.
    quiesce();
    write_reg(REG_AMPLITUDE, 32'd0);
    send_tick(1'b1);
    quiesce();
    write_reg(REG_AMPLITUDE, 32'h7FFF);
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    send_tick(1'b1);

    // Saw at zero amplitude restarts from 0 each tick: sample is the step.
    quiesce();
    write_reg(REG_WAVE_SHAPE, 32'(SHAPE_SAW));
    write_reg(REG_AMPLITUDE, 32'd0);
    write_reg(REG_SAW_STEP, 32'h7FFF);
    repeat (2) send_tick(1'b1);
    quiesce();
    write_reg(REG_AMPLITUDE, 32'h7FFF);
    repeat (2) send_tick(1'b1);

    // Square: periods 1 and 0 pin the counter at 0; period 2 lets it count.
    quiesce();
    write_reg(REG_WAVE_SHAPE, 32'(SHAPE_SQUARE));
    write_reg(REG_PERIOD, 32'd1);
    repeat (2) send_tick(1'b1);
    quiesce();
    write_reg(REG_PERIOD, 32'd0);
    send_tick(1'b1);
    quiesce();
    write_reg(REG_PERIOD, 32'd2);
    repeat (2) send_tick(1'b1);

    // Triangle with the largest step slams into both rails.
    quiesce();
    write_reg(REG_WAVE_SHAPE, 32'(SHAPE_TRI));
    write_reg(REG_PERIOD, 32'd4);
    write_reg(REG_TRI_STEP, 32'h7FFF);
    repeat (3) send_tick(1'b1);
    quiesce();
    write_reg(REG_PERIOD, 32'hFFFF);
    write_reg(REG_TRI_STEP, 32'd0);
    send_tick(1'b1);

    // Writes to unmapped indexes.
    quiesce();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    send_tick(1'b1);

    // ---- Random part ----
    // Segments: fresh settings while idle, then a burst of ticks. Shape is always
    // rewritten; other registers only sometimes, so state carries across shapes.
    ticks_sent = 0;
    seg        = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      quiesce();
      if (ticks_sent >= (2 * RANDOM_TICKS) / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (ticks_sent >= RANDOM_TICKS / 3) begin
        src_idle_pct  = 45;
        sink_idle_pct = 25;
      end

      write_reg(REG_WAVE_SHAPE, $urandom_range(3));
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(3))
          0:       v = 32'd0;
          1:       v = 32'h7FFF;
          default: v = $urandom_range(32767);
        endcase
        write_reg(REG_AMPLITUDE, v);
      end
      if ($urandom_range(9) < 6) begin
        // Mostly short periods so square and triangle wrap often.
        case ($urandom_range(9))
          0:       v = $urandom_range(1);
          1:       v = 32'hFFFF;
          2:       v = $urandom_range(65535);
          default: v = $urandom_range(40, 2);
        endcase
        write_reg(REG_PERIOD, v);
      end
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(5))
          0:       v = 32'd0;
          1:       v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
        write_reg(REG_PHASE_STEP, v);
      end
      if ($urandom_range(9) < 6) begin
        // Small steps let the ramp climb for many ticks before it wraps.
        case ($urandom_range(5))
          0:       v = 32'd0;
          1:       v = 32'h7FFF;
          2:       v = $urandom_range(32767);
          default: v = $urandom_range(4000);
        endcase
        write_reg(REG_SAW_STEP, v);
      end
      if ($urandom_range(9) < 6) begin
        case ($urandom_range(5))
          0:       v = 32'd0;
          1:       v = 32'h7FFF;
          2:       v = $urandom_range(32767);
          default: v = $urandom_range(4000);
        endcase
        write_reg(REG_TRI_STEP, v);
      end

      burst = $urandom_range(50, 15);
      // Now and then the receiver stalls long enough that the block backs up.
      if (seg % 6 == 2) begin
        hold_left = HOLD_CYCLES;
      end
      while (burst > 0) begin
        if ($urandom_range(11) == 0) begin
          send_tick(1'b0);
        end else begin
          send_tick(1'b1);
          burst--;
          ticks_sent++;
        end
      end
      seg++;
    end

    // Drain, then keep the clock running to catch any stray sample.
    quiesce();
    repeat (PIPE_LAT + 6) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_multi_waveform_oscillator_unit: done, clean");
    end else begin
      $display("tb_multi_waveform_oscillator_unit: done, errors");
    end
    $finish;
  end

endmodule
